// ----- sv/xcrc_pkg.sv -----
`timescale 1ns / 1ps
// shared types, byte codes and the crc-16/ccitt step for the xmodem-crc receiver
// no dependencies

package xcrc_pkg;

  localparam int CommitAddrW = 24;
  localparam int OffsetW     = 10;
  localparam int LenW        = 11;

  // protocol bytes
  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_STX = 8'h02;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_C   = 8'h43;

  localparam logic [LenW-1:0] LEN_SHORT = 11'd128;
  localparam logic [LenW-1:0] LEN_LONG  = 11'd1024;

  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_TOPBIT = 16'h8000;

  localparam logic [7:0] TRIES_RESET  = 8'd40;
  localparam logic [7:0] ERRORS_RESET = 8'd20;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    SESS_RUN  = 2'd0,
    SESS_OK   = 2'd1,
    SESS_FAIL = 2'd2
  } session_t;

  typedef enum logic [1:0] {
    NV_GOOD = 2'd0,
    NV_ERR  = 2'd1,
    NV_DUP  = 2'd2
  } nverdict_t;

  typedef enum logic {
    CFG_MAX_ERRORS    = 1'b0,
    CFG_INITIAL_TRIES = 1'b1
  } cfg_index_t;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_HDR  = 7'b0000010,
    PH_NUM  = 7'b0000100,
    PH_INV  = 7'b0001000,
    PH_DATA = 7'b0010000,
    PH_CRCH = 7'b0100000,
    PH_CRCL = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic                   kind;
    logic [7:0]             data_byte;
    logic [OffsetW-1:0]     byte_offset;
    logic                   commit;
    logic [CommitAddrW-1:0] commit_address;
    logic [LenW-1:0]        packet_length;
    logic [7:0]             response;
    logic [1:0]             session;
  } result_t;

  typedef struct packed {
    logic [7:0] max_errors;
    logic [7:0] initial_tries;
  } cfg_t;

  // one byte through crc-16/ccitt, msb first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOPBIT) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/xmodem_crc_receiver_core.sv -----
`timescale 1ns / 1ps
// top level of the xmodem-crc receiver: input register, protocol engine, result register
// depends on xcrc_pkg, xcrc_in_stage, xcrc_proto, xcrc_out_stage
//
//   channel   direction   handshake             payload
//   input     in          in_valid / in_stall   operation, rx_byte
//   result    out         out_valid / out_stall kind .. session
//   config    in          cfg_we                cfg_index, cfg_data
//
// one transaction per cycle sustained while the result register is not stalled; an accepted input
// transaction yields its result through the input register, then the result register
// the protocol state updates with each accepted transaction, crc-16 step is eight xor levels
// rst is synchronous and returns the session to idle and config to defaults
// a stalled result register holds the engine; the input register then stalls

module xmodem_crc_receiver_core #(
  parameter int ADDR_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  data_byte,
  output logic [9:0]  byte_offset,
  output logic        commit,
  output logic [23:0] commit_address,
  output logic [10:0] packet_length,
  output logic [7:0]  response,
  output logic [1:0]  session,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import xcrc_pkg::*;

  item_t   in_item, item;
  result_t res, out_res;
  logic    item_valid, take, res_valid, out_free;

  assign in_item.operation = operation;
  assign in_item.rx_byte   = rx_byte;

  xcrc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  xcrc_proto #(
    .ADDR_BITS (ADDR_BITS)
  ) u_proto (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  xcrc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign kind           = out_res.kind;
  assign data_byte      = out_res.data_byte;
  assign byte_offset    = out_res.byte_offset;
  assign commit         = out_res.commit;
  assign commit_address = out_res.commit_address;
  assign packet_length  = out_res.packet_length;
  assign response       = out_res.response;
  assign session        = out_res.session;

  // input side only stalls behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (item_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_commit_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && commit) |-> (kind == KIND_VERDICT &&
      (packet_length == LEN_SHORT || packet_length == LEN_LONG)))
    else $error("commit with bad packet length");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_DATA) |->
      (response == 8'd0 && session == SESS_RUN && !commit))
    else $error("data byte carries verdict fields");

  a_take_result: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_free) |=> (out_valid && out_res == $past(res)))
    else $error("result lost on its way to the result register");

endmodule

// ----- sv/xcrc_in_stage.sv -----
`timescale 1ns / 1ps
// input register of the xmodem-crc receiver: holds one accepted transaction
// depends on xcrc_pkg

module xcrc_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  xcrc_pkg::item_t in_item,
  output logic          in_stall,
  input  logic          take,
  output logic          item_valid,
  output xcrc_pkg::item_t item
);
  import xcrc_pkg::*;

  assign in_stall = item_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ----- sv/xcrc_proto.sv -----
`timescale 1ns / 1ps
// protocol engine: packet parser, crc check, verdict and session state
// depends on xcrc_pkg

module xcrc_proto #(
  parameter int ADDR_BITS = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_data,
  input  logic            item_valid,
  input  xcrc_pkg::item_t item,
  input  logic            out_free,
  output logic            take,
  output logic            res_valid,
  output xcrc_pkg::result_t res
);
  import xcrc_pkg::*;

  localparam int WideW = (ADDR_BITS > CommitAddrW) ? ADDR_BITS : CommitAddrW;

  cfg_t cfg;

  phase_t                phase, phase_next;
  logic                  starting, starting_next;
  logic [7:0]            start_tries, start_tries_next;
  logic [7:0]            expected_number, expected_number_next;
  logic [7:0]            header_number, header_number_next;
  logic [LenW-1:0]       bytes_left, bytes_left_next;
  logic                  long_packet, long_packet_next;
  logic [15:0]           running_crc, running_crc_next;
  logic [7:0]            crc_high, crc_high_next;
  nverdict_t             number_verdict, number_verdict_next;
  logic [7:0]            error_count, error_count_next;
  logic [ADDR_BITS-1:0]  write_address, write_address_next;

  // error outcome, shared by timeout and bad packet
  logic [7:0] tries_inc, errs_inc;
  phase_t     err_phase;
  logic [7:0] err_resp;
  session_t   err_session;

  logic [LenW-1:0] pkt_len, offset_full, bytes_dec;
  logic [WideW-1:0] addr_wide;
  nverdict_t  nv_hdr, nv_end;
  logic       do_error;

  assign take      = item_valid && out_free;
  assign pkt_len   = long_packet ? LEN_LONG : LEN_SHORT;
  assign offset_full = pkt_len - bytes_left;
  assign bytes_dec = (bytes_left != '0) ? bytes_left - LenW'(1) : bytes_left;
  assign addr_wide = WideW'(write_address);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_errors    <= ERRORS_RESET;
      cfg.initial_tries <= TRIES_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_MAX_ERRORS:    cfg.max_errors    <= cfg_data;
        CFG_INITIAL_TRIES: cfg.initial_tries <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    tries_inc = (start_tries != 8'hFF) ? start_tries + 8'd1 : start_tries;
    errs_inc  = (error_count != 8'hFF) ? error_count + 8'd1 : error_count;
    if (starting) begin
      err_resp = B_C;
      if (tries_inc >= cfg.initial_tries) begin
        err_phase   = PH_IDLE;
        err_session = SESS_FAIL;
      end else begin
        err_phase   = PH_HDR;
        err_session = SESS_RUN;
      end
    end else if (error_count > cfg.max_errors) begin
      err_phase   = PH_IDLE;
      err_resp    = B_CAN;
      err_session = SESS_FAIL;
    end else begin
      err_phase   = PH_HDR;
      err_resp    = B_NAK;
      err_session = SESS_RUN;
    end
  end

  // packet number check against its complement, the expected number and the previous one, and the crc compare
  always_comb begin
    nv_hdr = NV_GOOD;
    if (header_number != ~item.rx_byte || header_number != expected_number) begin
      nv_hdr = NV_ERR;
    end
    if (header_number == expected_number - 8'd1) begin
      nv_hdr = NV_DUP;
    end
    nv_end = ({crc_high, item.rx_byte} == running_crc) ? number_verdict : NV_ERR;
  end

  always_comb begin
    phase_next           = phase;
    starting_next        = starting;
    start_tries_next     = start_tries;
    expected_number_next = expected_number;
    header_number_next   = header_number;
    bytes_left_next      = bytes_left;
    long_packet_next     = long_packet;
    running_crc_next     = running_crc;
    crc_high_next        = crc_high;
    number_verdict_next  = number_verdict;
    error_count_next     = error_count;
    write_address_next   = write_address;
    res_valid            = 1'b0;
    res                  = '0;
    do_error             = 1'b0;

    if (take) begin
      case (item.operation)
        OP_START: begin
          phase_next           = PH_HDR;
          starting_next        = 1'b1;
          start_tries_next     = 8'd0;
          expected_number_next = 8'd1;
          error_count_next     = 8'd0;
          write_address_next   = '0;
        end
        OP_TICK: begin
          if (phase != PH_IDLE) begin
            do_error = 1'b1;
          end
        end
        OP_BYTE: begin
          case (phase)
            PH_HDR: begin
              if (item.rx_byte == B_SOH || item.rx_byte == B_STX) begin
                long_packet_next = (item.rx_byte == B_STX);
                phase_next       = PH_NUM;
              end else if (item.rx_byte == B_EOT || item.rx_byte == B_CAN) begin
                phase_next   = PH_IDLE;
                res_valid    = 1'b1;
                res.kind     = KIND_VERDICT;
                res.response = B_ACK;
                res.session  = (item.rx_byte == B_EOT) ? SESS_OK : SESS_FAIL;
              end
            end
            PH_NUM: begin
              header_number_next = item.rx_byte;
              phase_next         = PH_INV;
            end
            PH_INV: begin
              number_verdict_next = nv_hdr;
              bytes_left_next     = pkt_len;
              running_crc_next    = 16'h0000;
              phase_next          = PH_DATA;
            end
            PH_DATA: begin
              res_valid        = 1'b1;
              res.kind         = KIND_DATA;
              res.data_byte    = item.rx_byte;
              res.byte_offset  = offset_full[OffsetW-1:0];
              running_crc_next = crc_step(running_crc, item.rx_byte);
              bytes_left_next  = bytes_dec;
              if (bytes_dec == '0) begin
                phase_next = PH_CRCH;
              end
            end
            PH_CRCH: begin
              crc_high_next = item.rx_byte;
              phase_next    = PH_CRCL;
            end
            PH_CRCL: begin
              if (nv_end == NV_GOOD) begin
                res_valid            = 1'b1;
                res.kind             = KIND_VERDICT;
                res.commit           = 1'b1;
                res.commit_address   = addr_wide[CommitAddrW-1:0];
                res.packet_length    = pkt_len;
                res.response         = B_ACK;
                res.session          = SESS_RUN;
                write_address_next   = write_address + ADDR_BITS'(pkt_len);
                error_count_next     = 8'd0;
                expected_number_next = expected_number + 8'd1;
                starting_next        = 1'b0;
                phase_next           = PH_HDR;
              end else if (nv_end == NV_DUP) begin
                res_valid     = 1'b1;
                res.kind      = KIND_VERDICT;
                res.response  = B_ACK;
                res.session   = SESS_RUN;
                starting_next = 1'b0;
                phase_next    = PH_HDR;
              end else begin
                do_error = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    if (do_error) begin
      phase_next   = err_phase;
      res_valid    = 1'b1;
      res          = '0;
      res.kind     = KIND_VERDICT;
      res.response = err_resp;
      res.session  = err_session;
      if (starting) begin
        start_tries_next = tries_inc;
      end else if (err_session == SESS_RUN) begin
        error_count_next = errs_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      starting        <= 1'b1;
      start_tries     <= 8'd0;
      expected_number <= 8'd1;
      header_number   <= 8'd0;
      bytes_left      <= '0;
      long_packet     <= 1'b0;
      running_crc     <= 16'h0000;
      crc_high        <= 8'd0;
      number_verdict  <= NV_GOOD;
      error_count     <= 8'd0;
      write_address   <= '0;
    end else begin
      phase           <= phase_next;
      starting        <= starting_next;
      start_tries     <= start_tries_next;
      expected_number <= expected_number_next;
      header_number   <= header_number_next;
      bytes_left      <= bytes_left_next;
      long_packet     <= long_packet_next;
      running_crc     <= running_crc_next;
      crc_high        <= crc_high_next;
      number_verdict  <= number_verdict_next;
      error_count     <= error_count_next;
      write_address   <= write_address_next;
    end
  end

endmodule

// ----- sv/xcrc_out_stage.sv -----
`timescale 1ns / 1ps
// result register of the xmodem-crc receiver
// depends on xcrc_pkg

module xcrc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  xcrc_pkg::result_t res,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_stall,
  output xcrc_pkg::result_t out_res
);
  import xcrc_pkg::*;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_res <= res;
    end
  end

endmodule

// ----- verif/tb_xmodem_crc_receiver_core.sv -----
`timescale 1ns / 1ps
// self-checking testbench for xmodem_crc_receiver_core: queued stimulus, clocked driver and monitor
// depends on xcrc_pkg and the receiver rtl

module tb_xmodem_crc_receiver_core;
  import xcrc_pkg::*;

  localparam logic [1:0] OP_UNUSED       = 2'd3;
  localparam int         HOLD_OFF_CYCLES = 300;
  localparam int         WATCHDOG_LIMIT  = 4000;
  localparam int         PHASE_ITEMS     = 100;
  localparam int         CUT_KEEP_MAX    = 160;

  typedef enum int {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_t;
  typedef enum int {PK_GOOD, PK_DUP, PK_BADNUM, PK_BADINV, PK_BADCRC, PK_CUT} pkt_kind_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = 2'd0;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [7:0]  data_byte;
  logic [9:0]  byte_offset;
  logic        commit;
  logic [23:0] commit_address;
  logic [10:0] packet_length;
  logic [7:0]  response;
  logic [1:0]  session;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = 8'd0;

  xmodem_crc_receiver_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .data_byte(data_byte),
    .byte_offset(byte_offset), .commit(commit), .commit_address(commit_address),
    .packet_length(packet_length), .response(response), .session(session),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  item_t     tx_items[$];
  result_t   due_results[$];
  item_t     next_item;
  result_t   want;
  gap_mode_t gap_mode = GAP_NONE;
  logic      in_taken = 1'b0;
  int        fail_count = 0;
  int        useful_items = 0;
  int        quiet_cycles = 0;
  int        hold_asks = 0;
  int        hold_served = 0;
  int        hold_left = 0;

  // receiver model state
  logic [7:0]  m_max_errors = ERRORS_RESET;
  logic [7:0]  m_tries_limit = TRIES_RESET;
  phase_t      m_phase = PH_IDLE;
  logic        m_starting = 1'b1;
  logic [7:0]  m_tries = 8'd0;
  logic [7:0]  m_expected = 8'd1;
  logic [7:0]  m_hdr = 8'd0;
  logic [10:0] m_left = 11'd0;
  logic        m_long = 1'b0;
  logic [15:0] m_crc = 16'd0;
  logic [7:0]  m_crc_high = 8'd0;
  nverdict_t   m_verdict = NV_GOOD;
  logic [7:0]  m_errors = 8'd0;
  logic [23:0] m_addr = 24'd0;

  function automatic bit pct_hit(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  // crc-16/ccitt, one message bit at a time
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic logic [10:0] model_len();
    return m_long ? LEN_LONG : LEN_SHORT;
  endfunction

  function automatic result_t make_verdict(input logic c, input logic [23:0] a,
                                           input logic [10:0] l, input logic [7:0] resp,
                                           input session_t s);
    result_t r;
    r = '0;
    r.kind = KIND_VERDICT;
    r.commit = c;
    r.commit_address = a;
    r.packet_length = l;
    r.response = resp;
    r.session = s;
    return r;
  endfunction

  function automatic result_t error_verdict();
    if (m_starting) begin
      if (m_tries < 8'hFF) m_tries++;
      if (m_tries >= m_tries_limit) begin
        m_phase = PH_IDLE;
        return make_verdict(1'b0, '0, '0, B_C, SESS_FAIL);
      end
      m_phase = PH_HDR;
      return make_verdict(1'b0, '0, '0, B_C, SESS_RUN);
    end
    if (m_errors > m_max_errors) begin
      m_phase = PH_IDLE;
      return make_verdict(1'b0, '0, '0, B_CAN, SESS_FAIL);
    end
    if (m_errors < 8'hFF) m_errors++;
    m_phase = PH_HDR;
    return make_verdict(1'b0, '0, '0, B_NAK, SESS_RUN);
  endfunction

  // advance the model by one accepted transaction and queue what it must produce
  function automatic void parse_item(input logic [1:0] op, input logic [7:0] b);
    result_t     r;
    logic [15:0] rcv;
    nverdict_t   nv;
    r = '0;
    if (op == OP_START) begin
      m_phase = PH_HDR;
      m_starting = 1'b1;
      m_tries = 8'd0;
      m_expected = 8'd1;
      m_errors = 8'd0;
      m_addr = 24'd0;
      useful_items++;
      return;
    end
    if (op == OP_UNUSED || m_phase == PH_IDLE) return;
    if (op == OP_TICK) begin
      useful_items++;
      due_results.push_back(error_verdict());
      return;
    end
    case (m_phase)
      PH_HDR: begin
        if (b == B_SOH || b == B_STX) begin
          m_long = (b == B_STX);
          m_phase = PH_NUM;
          useful_items++;
        end else if (b == B_EOT || b == B_CAN) begin
          m_phase = PH_IDLE;
          useful_items++;
          due_results.push_back(make_verdict(1'b0, '0, '0, B_ACK,
                                             (b == B_EOT) ? SESS_OK : SESS_FAIL));
        end
      end
      PH_NUM: begin
        m_hdr = b;
        m_phase = PH_INV;
        useful_items++;
      end
      PH_INV: begin
        nv = NV_GOOD;
        if (m_hdr != ~b || m_hdr != m_expected) nv = NV_ERR;
        if (m_hdr == 8'(m_expected - 8'd1)) nv = NV_DUP;
        m_verdict = nv;
        m_left = model_len();
        m_crc = 16'd0;
        m_phase = PH_DATA;
        useful_items++;
      end
      PH_DATA: begin
        r.kind = KIND_DATA;
        r.data_byte = b;
        r.byte_offset = 10'(model_len() - m_left);
        due_results.push_back(r);
        m_crc = crc16_byte(m_crc, b);
        m_left--;
        if (m_left == 11'd0) m_phase = PH_CRCH;
        useful_items++;
      end
      PH_CRCH: begin
        m_crc_high = b;
        m_phase = PH_CRCL;
        useful_items++;
      end
      default: begin
        useful_items++;
        rcv = {m_crc_high, b};
        nv = m_verdict;
        if (rcv != m_crc) nv = NV_ERR;
        if (nv == NV_GOOD) begin
          due_results.push_back(make_verdict(1'b1, m_addr, model_len(), B_ACK, SESS_RUN));
          m_addr = m_addr + 24'(model_len());
          m_errors = 8'd0;
          m_expected = m_expected + 8'd1;
          m_starting = 1'b0;
          m_phase = PH_HDR;
        end else if (nv == NV_DUP) begin
          due_results.push_back(make_verdict(1'b0, '0, '0, B_ACK, SESS_RUN));
          m_starting = 1'b0;
          m_phase = PH_HDR;
        end else begin
          due_results.push_back(error_verdict());
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [23:0] exp_val,
                                      input logic [23:0] got);
    if (got !== exp_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got);
      fail_count++;
    end
  endfunction

  function automatic item_t byte_item(input logic [7:0] b);
    item_t it;
    it.operation = OP_BYTE;
    it.rx_byte = b;
    return it;
  endfunction

  function automatic item_t op_item(input logic [1:0] op);
    item_t it;
    it.operation = op;
    it.rx_byte = 8'($urandom);
    return it;
  endfunction

  function automatic logic [7:0] stray_byte();
    logic [7:0] d;
    do d = 8'($urandom);
    while (d == B_SOH || d == B_STX || d == B_EOT || d == B_CAN);
    return d;
  endfunction

  // driver: inputs move on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (tx_items.size() != 0 &&
          !pct_hit(gap_mode == GAP_SEND ? 50 : gap_mode == GAP_BOTH ? 15 : 0)) begin
        next_item = tx_items.pop_front();
        in_valid <= 1'b1;
        operation <= next_item.operation;
        rx_byte <= next_item.rx_byte;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure, with the occasional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_asks != hold_served) begin
      hold_served++;
      hold_left = HOLD_OFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= pct_hit(gap_mode == GAP_RECV ? 50 : gap_mode == GAP_BOTH ? 15 : 0);
    end
  end

  // monitor: both channels sampled on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) parse_item(operation, rx_byte);
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result with nothing due: kind %0d response 0x%0h", kind, response);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("kind", 24'(want.kind), 24'(kind));
          check_field("data_byte", 24'(want.data_byte), 24'(data_byte));
          check_field("byte_offset", 24'(want.byte_offset), 24'(byte_offset));
          check_field("commit", 24'(want.commit), 24'(commit));
          check_field("commit_address", want.commit_address, commit_address);
          check_field("packet_length", 24'(want.packet_length), 24'(packet_length));
          check_field("response", 24'(want.response), 24'(response));
          check_field("session", 24'(want.session), 24'(session));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
    in_taken <= !rst && in_valid && !in_stall;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb_xmodem_crc_receiver_core: errors");
    $finish;
  end

  // every queued transaction has been taken and the model is up to date
  task automatic wait_sender_idle();
    @(posedge clk);
    while (tx_items.size() != 0 || in_valid) @(posedge clk);
  endtask

  task automatic wait_quiet();
    wait_sender_idle();
    while (due_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_ERRORS) m_max_errors = value;
    else m_tries_limit = value;
  endtask

  // only called with the sender idle, so the model numbering is current
  task automatic queue_packet(input pkt_kind_t k, input bit long_pkt);
    item_t       pkt[$];
    logic [7:0]  num;
    logic [7:0]  inv;
    logic [7:0]  d;
    logic [15:0] crc;
    int          n;
    int          keep;
    num = m_expected;
    if (k == PK_DUP) num = m_expected - 8'd1;
    else if (k == PK_BADNUM) num = m_expected + 8'($urandom_range(1, 254));
    inv = ~num;
    if (k == PK_BADINV) inv = inv ^ 8'($urandom_range(1, 255));
    n = long_pkt ? 1024 : 128;
    pkt.push_back(byte_item(long_pkt ? B_STX : B_SOH));
    pkt.push_back(byte_item(num));
    pkt.push_back(byte_item(inv));
    crc = 16'd0;
    for (int i = 0; i < n; i++) begin
      d = pct_hit(10) ? ($urandom_range(1) ? 8'h00 : 8'hFF) : 8'($urandom);
      crc = crc16_byte(crc, d);
      pkt.push_back(byte_item(d));
    end
    if (k == PK_BADCRC) crc = crc ^ 16'($urandom_range(1, 65535));
    pkt.push_back(byte_item(crc[15:8]));
    pkt.push_back(byte_item(crc[7:0]));
    if (k == PK_CUT) begin
      // packet broken off, then the line times out
      keep = $urandom_range(1, (pkt.size() > CUT_KEEP_MAX) ? CUT_KEEP_MAX : pkt.size() - 1);
      while (pkt.size() > keep) void'(pkt.pop_back());
      pkt.push_back(op_item(OP_TICK));
    end
    foreach (pkt[i]) tx_items.push_back(pkt[i]);
  endtask

  task automatic random_step();
    int pick;
    int n;
    bit long_pkt;
    wait_sender_idle();
    pick = $urandom_range(99);
    long_pkt = ($urandom_range(3) == 0);
    if (pct_hit(8)) wait_quiet();
    if (m_phase == PH_IDLE) begin
      if (pick < 15) begin
        n = $urandom_range(1, 4);
        repeat (n) tx_items.push_back(byte_item(8'($urandom)));
        tx_items.push_back(op_item(pick < 7 ? OP_UNUSED : OP_TICK));
      end else begin
        tx_items.push_back(op_item(OP_START));
      end
    end else if (pick < 55) queue_packet(PK_GOOD, 1'b0);
    else if (pick < 62) queue_packet(PK_DUP, 1'b0);
    else if (pick < 67) queue_packet(PK_BADNUM, 1'b0);
    else if (pick < 72) queue_packet(PK_BADINV, 1'b0);
    else if (pick < 78) queue_packet(PK_BADCRC, 1'b0);
    else if (pick < 85) queue_packet(PK_CUT, long_pkt);
    else if (pick < 91) begin
      n = $urandom_range(1, 25);
      repeat (n) tx_items.push_back(op_item(OP_TICK));
    end else if (pick < 95) begin
      n = $urandom_range(1, 4);
      repeat (n) tx_items.push_back(byte_item(stray_byte()));
    end else if (pick < 97) tx_items.push_back(byte_item(pick == 95 ? B_EOT : B_CAN));
    else if (pick < 99) tx_items.push_back(op_item(OP_START));
    else tx_items.push_back(op_item(OP_UNUSED));
  endtask

  initial begin
    int target;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed: idle noise, stray bytes, start-up timeout, eot, can, packets broken off after the header
    tx_items.push_back(byte_item(B_SOH));
    tx_items.push_back(op_item(OP_TICK));
    tx_items.push_back(op_item(OP_UNUSED));
    tx_items.push_back(op_item(OP_START));
    tx_items.push_back(byte_item(8'h00));
    tx_items.push_back(byte_item(8'hFF));
    tx_items.push_back(op_item(OP_TICK));
    tx_items.push_back(byte_item(B_EOT));
    tx_items.push_back(op_item(OP_START));
    tx_items.push_back(byte_item(B_CAN));
    tx_items.push_back(op_item(OP_START));
    tx_items.push_back(byte_item(B_SOH));
    tx_items.push_back(byte_item(8'h01));
    tx_items.push_back(byte_item(8'hFE));
    tx_items.push_back(byte_item(8'h5A));
    tx_items.push_back(op_item(OP_TICK));
    tx_items.push_back(op_item(OP_UNUSED));
    tx_items.push_back(byte_item(B_STX));
    tx_items.push_back(byte_item(8'h00));
    tx_items.push_back(byte_item(8'hFF));
    tx_items.push_back(op_item(OP_START));
    tx_items.push_back(byte_item(B_EOT));

    for (int ph = 1; ph <= 4; ph++) begin
      wait_quiet();
      repeat (4) @(negedge clk);
      case (ph)
        1: begin
          write_reg(CFG_MAX_ERRORS, 8'd0);
          write_reg(CFG_INITIAL_TRIES, 8'd1);
          gap_mode = GAP_SEND;
        end
        2: begin
          write_reg(CFG_MAX_ERRORS, 8'd255);
          write_reg(CFG_INITIAL_TRIES, 8'd255);
          gap_mode = GAP_RECV;
        end
        3: begin
          write_reg(CFG_MAX_ERRORS, 8'd3);
          write_reg(CFG_INITIAL_TRIES, 8'd5);
          gap_mode = GAP_BOTH;
        end
        default: begin
          write_reg(CFG_MAX_ERRORS, 8'($urandom_range(0, 30)));
          write_reg(CFG_INITIAL_TRIES, 8'($urandom_range(1, 60)));
          gap_mode = GAP_NONE;
        end
      endcase
      if (ph == 2 || ph == 4) begin
        tx_items.push_back(op_item(OP_START));
        wait_sender_idle();
        // results back up behind the hold-off until the input side stalls
        if (ph == 2) hold_asks++;
        queue_packet(PK_GOOD, 1'b0);
      end
      target = useful_items + PHASE_ITEMS;
      while (useful_items < target) random_step();
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("tb_xmodem_crc_receiver_core: clean");
    else $display("tb_xmodem_crc_receiver_core: errors");
    $finish;
  end

endmodule
